FILE: rtl/core/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// shared types, widths and constants of the four channel temperature alarm
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned CH_MAX     = 4;
  localparam int unsigned MV_W       = 12;
  localparam int unsigned TEMP_W     = 14;
  localparam int unsigned LVL_W      = 2;
  localparam int unsigned LIMIT_W    = 14;
  localparam int unsigned BAND_W     = 12;
  localparam int unsigned CV_W       = 9;   // hundredths of a volt, 0..300
  localparam int unsigned CMP_W      = 16;  // threshold sums, no wrap
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned CH_DEFAULT = 4;

  localparam logic [LIMIT_W-1:0] PREV_RESET  = LIMIT_W'(8000);
  localparam logic [LIMIT_W-1:0] EMERG_RESET = LIMIT_W'(11000);
  localparam logic [BAND_W-1:0]  BAND_RESET  = BAND_W'(200);

  localparam logic [CV_W-1:0]   CV_MAX     = CV_W'(300);
  localparam logic [15:0]       RECIP_TEN  = 16'd52429;  // 2^19 / 10, rounded up
  localparam int unsigned       TEN_SHIFT  = 19;
  localparam logic [15:0]       RECIP_THREE = 16'd43691; // 2^17 / 3, rounded up
  localparam int unsigned       THREE_SHIFT = 17;
  localparam logic [TEMP_W-1:0] TEMP_BASE  = TEMP_W'(3000);

  typedef enum logic [1:0] {
    REG_PREV  = 2'd0,
    REG_EMERG = 2'd1,
    REG_BAND  = 2'd2
  } reg_idx_e;

  typedef enum logic [LVL_W-1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_PREVENT = 2'd1,
    LVL_EMERG   = 2'd2
  } lvl_e;

  typedef struct packed {
    logic adv;      // pipeline moves this cycle
    logic s3_load;  // stage two holds an item reaching the state update
  } lane_ctrl_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] prev_limit;
    logic [LIMIT_W-1:0] emerg_limit;
    logic [BAND_W-1:0]  band;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    lvl_e              level;
    logic              changed;
  } lane_res_t;

endpackage

FILE: rtl/core/tca_lane.sv
// ----------------------------------------------------------------------------
// tca_lane
// one channel: millivolt to temperature conversion and alarm level update
// ----------------------------------------------------------------------------
module tca_lane
  import tca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  cfg_t              cfg_i,
  input  logic [MV_W-1:0]   volts_i,
  output lane_res_t         res_o
);

  logic [CV_W-1:0]   cv_q, cv_d;
  logic [TEMP_W-1:0] temp_q, temp_d;
  lvl_e              level_q, level_d;

  logic [MV_W:0]     mv_rnd;
  logic [28:0]       div_ten;
  logic [9:0]        cv_raw;
  logic [15:0]       scaled;
  logic [31:0]       div_three;
  logic [CMP_W-1:0]  t_w, p_w, e_w, b_w;

  // stage one: (mv + 5) / 10, clamped
  always_comb begin
    mv_rnd  = {1'b0, volts_i} + (MV_W+1)'(5);
    div_ten = 29'(mv_rnd) * 29'(RECIP_TEN);
    cv_raw  = div_ten[TEN_SHIFT +: 10];
    cv_d    = (cv_raw > 10'(CV_MAX)) ? CV_MAX : cv_raw[CV_W-1:0];
  end

  // stage two: 3000 + (v * 110 + 1) / 3
  always_comb begin
    scaled    = (16'(cv_q) << 7) - (16'(cv_q) << 4) - (16'(cv_q) << 1) + 16'd1;
    div_three = 32'(scaled) * 32'(RECIP_THREE);
    temp_d    = TEMP_BASE + div_three[THREE_SHIFT +: TEMP_W];
  end

  // stage three: next level
  always_comb begin
    t_w = CMP_W'(temp_q);
    p_w = CMP_W'(cfg_i.prev_limit);
    e_w = CMP_W'(cfg_i.emerg_limit);
    b_w = CMP_W'(cfg_i.band);
    level_d = level_q;
    case (level_q)
      LVL_NORMAL: begin
        if (t_w > p_w + b_w) level_d = LVL_PREVENT;
      end
      LVL_PREVENT: begin
        if (t_w > e_w + b_w) level_d = LVL_EMERG;
        else if (t_w + b_w < p_w) level_d = LVL_NORMAL;
      end
      LVL_EMERG: begin
        if (t_w + b_w < e_w) level_d = LVL_PREVENT;
      end
      default: level_d = LVL_NORMAL;
    endcase
  end

  always_comb begin
    res_o.temp    = temp_q;
    res_o.level   = level_d;
    res_o.changed = (level_d != level_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      cv_q   <= cv_d;
      temp_q <= temp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LVL_NORMAL;
    end else if (ctrl_i.s3_load) begin
      level_q <= level_d;
    end
  end

endmodule

FILE: rtl/core/tca_merge.sv
// ----------------------------------------------------------------------------
// tca_merge
// gathers the lane results into the output register of the result stream
// ----------------------------------------------------------------------------
module tca_merge
  import tca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lane_ctrl_t            ctrl_i,
  input  lane_res_t [CH_MAX-1:0] res_i,
  output logic                  valid_o,
  output logic [OUT_DATA_W-1:0] data_o
);

  logic                  valid_q, valid_d;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic [CH_MAX-1:0]     mask;

  always_comb begin
    data_d = '0;
    for (int i = 0; i < CH_MAX; i++) begin
      mask[i] = res_i[i].changed;
      data_d[i*TEMP_W +: TEMP_W] = res_i[i].temp;
      data_d[CH_MAX*TEMP_W + i*LVL_W +: LVL_W] = res_i[i].level;
    end
    data_d[CH_MAX*(TEMP_W+LVL_W) +: CH_MAX] = mask;
    valid_d = ctrl_i.adv ? ctrl_i.s3_load : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3_load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/four_channel_temperature_alarm.sv
// ----------------------------------------------------------------------------
// four_channel_temperature_alarm
// four millivolt channels to temperature with a three level hysteresis alarm
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one transfer carries four 12 bit millivolt samples
//   master stream: four temperatures in 0.01 degree, four new alarm levels
//   and a mask of channels whose level changed
//   apb port: preventive limit at 0x0, emergency limit at 0x4, band at 0x8,
//   write only while no transfer is in flight
// throughput: one transfer per cycle when not stalled; each lane has a three stage pipeline
//   (divide by ten, scale by 110/3, level update) and the level register
//   closes its loop in the last stage alone
// reset: all levels normal, limits 8000 / 11000, band 200, pipeline empty
// stall: while a result waits on the master side the whole pipeline holds
//   and s_axis_tready is low; bubbles ahead of the output are not squeezed
// unused lanes (index at or above CHANNELS) report zero
// ----------------------------------------------------------------------------
module four_channel_temperature_alarm
  import tca_pkg::*;
#(
  parameter int unsigned CHANNELS = CH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // volts_a, volts_b, volts_c, volts_d
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // temp_a..temp_d, level_a..level_d,
                                                // changed_mask, zero pad
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t        cfg_q;
  lane_ctrl_t  ctrl;
  logic        v1_q, v2_q;
  logic        stall;
  logic        cfg_wr;
  reg_idx_e    reg_idx;
  lane_res_t [CH_MAX-1:0] res;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prev_limit  <= PREV_RESET;
      cfg_q.emerg_limit <= EMERG_RESET;
      cfg_q.band        <= BAND_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PREV:  cfg_q.prev_limit  <= pwdata[LIMIT_W-1:0];
        REG_EMERG: cfg_q.emerg_limit <= pwdata[LIMIT_W-1:0];
        REG_BAND:  cfg_q.band        <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PREV:  prdata = APB_DATA_W'(cfg_q.prev_limit);
      REG_EMERG: prdata = APB_DATA_W'(cfg_q.emerg_limit);
      REG_BAND:  prdata = APB_DATA_W'(cfg_q.band);
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  assign stall         = m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = !stall;

  always_comb begin
    ctrl.adv     = !stall;
    ctrl.s3_load = !stall && v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (ctrl.adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
    end
  end

  // lanes
  for (genvar g = 0; g < CH_MAX; g++) begin : g_lane
    if (g < CHANNELS) begin : g_on
      tca_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .cfg_i   (cfg_q),
        .volts_i (s_axis_tdata[g*MV_W +: MV_W]),
        .res_o   (res[g])
      );
    end else begin : g_off
      assign res[g] = '0;
    end
  end

  tca_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .res_i   (res),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

  // checks
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == !(m_axis_tvalid && !m_axis_tready))
    else $error("input ready does not follow output stall");

  a_level_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[57:56] != 2'd3 && m_axis_tdata[59:58] != 2'd3 &&
                       m_axis_tdata[61:60] != 2'd3 && m_axis_tdata[63:62] != 2'd3))
    else $error("undefined alarm level reported");

  a_lane_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.s3_load |=> m_axis_tvalid)
    else $error("level update without a result");

endmodule

FILE: tb/four_channel_temperature_alarm_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_channel_temperature_alarm_test
// self checking bench for the four channel temperature alarm: every sample
// transfer is predicted in the bench (rounding, clamp, linear scale, one step
// hysteresis walk per channel) and each master side transfer is compared field
// by field against the oldest prediction, with random gaps and stalls on both
// streams and limit changes over the apb port between phases
// ----------------------------------------------------------------------------
module four_channel_temperature_alarm_test;
  import tca_pkg::*;

  localparam int          PIPE_LATENCY = 3;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          REPORT_CAP   = 40;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 105;
  localparam int          MV_TOP       = 4095;
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(12);

  typedef struct packed {
    logic [CH_MAX-1:0]             changed;
    logic [CH_MAX-1:0][LVL_W-1:0]  level;
    logic [CH_MAX-1:0][TEMP_W-1:0] temp;
  } alarm_report_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  alarm_report_t pending_reports[$];
  lvl_e          lvl_track[CH_MAX];
  logic [LIMIT_W-1:0] prev_limit_sh;
  logic [LIMIT_W-1:0] emerg_limit_sh;
  logic [BAND_W-1:0]  band_sh;
  int  walk_mv[CH_MAX];
  bit  src_idle_on;
  bit  sink_idle_on;
  int  mismatch_count;
  int  cycle_count;

  four_channel_temperature_alarm u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] reg_addr(input reg_idx_e idx);
    return {idx, 2'b00};
  endfunction

  // temperature and next level per channel, advancing the tracked levels
  function automatic alarm_report_t predict_alarm_report(input logic [CH_MAX-1:0][MV_W-1:0] mv);
    alarm_report_t rep;
    int centi_volts;
    int degrees;
    int p;
    int e;
    int b;
    lvl_e now_lvl;
    lvl_e next_lvl;
    rep = '0;
    p = int'(prev_limit_sh);
    e = int'(emerg_limit_sh);
    b = int'(band_sh);
    for (int ch = 0; ch < CH_MAX; ch++) begin
      centi_volts = (int'(mv[ch]) + 5) / 10;
      if (centi_volts > 300) centi_volts = 300;
      degrees = 3000 + (centi_volts * 110 + 1) / 3;
      now_lvl = lvl_track[ch];
      next_lvl = now_lvl;
      case (now_lvl)
        LVL_NORMAL: begin
          if (degrees > p + b) next_lvl = LVL_PREVENT;
        end
        LVL_PREVENT: begin
          if (degrees > e + b) next_lvl = LVL_EMERG;
          else if (degrees < p - b) next_lvl = LVL_NORMAL;
        end
        LVL_EMERG: begin
          if (degrees < e - b) next_lvl = LVL_PREVENT;
        end
        default: begin
          next_lvl = LVL_NORMAL;
        end
      endcase
      rep.temp[ch] = TEMP_W'(degrees);
      rep.level[ch] = next_lvl;
      rep.changed[ch] = (next_lvl != now_lvl);
      lvl_track[ch] = next_lvl;
    end
    return rep;
  endfunction

  task automatic report_mismatch(input string what, input int ch, input int got,
                                 input int want);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch %s ch%0d: got %0d want %0d at %0t", what, ch, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [CH_MAX-1:0][MV_W-1:0] mv);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= mv;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.push_back(predict_alarm_report(mv));
  endtask

  // stop sending and let every predicted transfer come out
  task automatic settle_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[3:2])
      REG_PREV:  prev_limit_sh = value[LIMIT_W-1:0];
      REG_EMERG: emerg_limit_sh = value[LIMIT_W-1:0];
      REG_BAND:  band_sh = value[BAND_W-1:0];
      default:   ;
    endcase
  endtask

  task automatic write_limits(input int prev, input int emerg, input int band);
    logic [31:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    write_register(reg_addr(REG_PREV), 32'(prev) | (junk << LIMIT_W));
    write_register(reg_addr(REG_EMERG), 32'(emerg) | (junk << LIMIT_W));
    write_register(reg_addr(REG_BAND), 32'(band) | (junk << BAND_W));
  endtask

  // rounding corners, clamp point and both field extremes
  task automatic test_conversion_edges();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    send_sample({12'd0, 12'd0, 12'd0, 12'd0});
    send_sample({12'd4095, 12'd4095, 12'd4095, 12'd4095});
    send_sample({12'd15, 12'd14, 12'd5, 12'd4});
    send_sample({12'd3000, 12'd2996, 12'd2995, 12'd2994});
    send_sample({12'd2047, 12'd4094, 12'd2048, 12'd1});
    send_sample({12'd2730, 12'd2735, 12'd1390, 12'd1395});
  endtask

  // channels climbing and falling through all levels, one step at a time
  task automatic test_level_steps();
    send_sample({12'd0, 12'd1390, 12'd4095, 12'd4095});
    send_sample({12'd1390, 12'd4095, 12'd4095, 12'd4095});
    send_sample({12'd4095, 12'd2300, 12'd0, 12'd2100});
    send_sample({12'd4095, 12'd2200, 12'd0, 12'd0});
    send_sample({12'd1390, 12'd0, 12'd1390, 12'd0});
    send_sample({12'd0, 12'd0, 12'd0, 12'd1390});
  endtask

  task automatic test_register_extremes();
    settle_pipeline();
    write_limits(0, 0, 0);
    send_sample({12'd0, 12'd4095, 12'd0, 12'd9});
    send_sample({12'd0, 12'd4095, 12'd0, 12'd9});
    settle_pipeline();
    // every field at its maximum: both limits 16383, band 4095
    write_register(reg_addr(REG_PREV), 32'hFFFF_FFFF);
    write_register(reg_addr(REG_EMERG), 32'hFFFF_FFFF);
    write_register(reg_addr(REG_BAND), 32'hFFFF_FFFF);
    send_sample({12'd4095, 12'd0, 12'd4095, 12'd0});
    send_sample({12'd4095, 12'd0, 12'd4095, 12'd0});
    settle_pipeline();
    write_limits(2000, 0, 4095);
    send_sample({12'd0, 12'd0, 12'd4095, 12'd0});
    send_sample({12'd0, 12'd0, 12'd4095, 12'd0});
    settle_pipeline();
    // crossed limits, emergency below preventive
    write_limits(12000, 5000, 100);
    send_sample({12'd4095, 12'd1000, 12'd3000, 12'd500});
    send_sample({12'd4095, 12'd1000, 12'd3000, 12'd500});
    send_sample({12'd0, 12'd2500, 12'd500, 12'd4095});
    settle_pipeline();
    write_register(UNUSED_ADDR, 32'hFFFF_FFFF);
    send_sample({12'd2500, 12'd2500, 12'd2500, 12'd2500});
    settle_pipeline();
    write_limits(8000, 11000, 200);
  endtask

  task automatic test_random_traffic();
    logic [CH_MAX-1:0][MV_W-1:0] mv;
    int prev;
    int step;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_pipeline();
      case ($urandom_range(0, 3))
        0: write_limits(8000, 11000, 200);
        1: begin
          prev = $urandom_range(3000, 12000);
          write_limits(prev, $urandom_range(prev, 14000), $urandom_range(0, 800));
        end
        2: write_limits($urandom_range(0, 16383), $urandom_range(0, 16383),
                        $urandom_range(0, 4095));
        default: write_limits($urandom_range(0, 1) * 16383, $urandom_range(0, 1) * 16383,
                              $urandom_range(0, 1) * 4095);
      endcase
      src_idle_on = (phase % 4 == 1) ? 1'b0 : bit'($urandom_range(0, 1));
      sink_idle_on = (phase % 4 == 1) ? 1'b0 : bit'($urandom_range(0, 1));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          for (int ch = 0; ch < CH_MAX; ch++) mv[ch] = MV_W'($urandom_range(0, MV_TOP));
        end else begin
          // slow per channel drift so the levels walk across the thresholds
          for (int ch = 0; ch < CH_MAX; ch++) begin
            step = $urandom_range(0, 800) - 400;
            walk_mv[ch] = walk_mv[ch] + step;
            if (walk_mv[ch] < 0) walk_mv[ch] = 0;
            if (walk_mv[ch] > MV_TOP) walk_mv[ch] = MV_TOP;
            mv[ch] = MV_W'(walk_mv[ch]);
          end
        end
        send_sample(mv);
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    alarm_report_t got;
    alarm_report_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata[$bits(alarm_report_t)-1:0];
      if (pending_reports.size() == 0) begin
        report_mismatch("transfer with nothing pending", 0, 0, 0);
      end else begin
        want = pending_reports.pop_front();
        for (int ch = 0; ch < CH_MAX; ch++) begin
          if (got.temp[ch] !== want.temp[ch])
            report_mismatch("temp", ch, int'(got.temp[ch]), int'(want.temp[ch]));
          if (got.level[ch] !== want.level[ch])
            report_mismatch("level", ch, int'(got.level[ch]), int'(want.level[ch]));
        end
        if (got.changed !== want.changed)
          report_mismatch("changed_mask", 0, int'(got.changed), int'(want.changed));
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cycle_count <= 0;
    mismatch_count = 0;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    prev_limit_sh = PREV_RESET;
    emerg_limit_sh = EMERG_RESET;
    band_sh = BAND_RESET;
    for (int ch = 0; ch < CH_MAX; ch++) begin
      lvl_track[ch] = LVL_NORMAL;
      walk_mv[ch] = 1500;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_conversion_edges();
    test_level_steps();
    test_register_extremes();
    test_random_traffic();
    settle_pipeline();

    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tca_pkg.sv
rtl/core/tca_lane.sv
rtl/core/tca_merge.sv
rtl/core/four_channel_temperature_alarm.sv
tb/four_channel_temperature_alarm_test.sv
